FILE: rtl/mrcrc_pkg.sv
// Shared types, constants and the CRC-16 byte fold for the Modbus RTU frame CRC engine.
`timescale 1ns / 1ps

package mrcrc_pkg;

   localparam int MAX_FRAME_DEFAULT = 256;
   localparam int LEN_W             = 9;
   localparam int CRC_W             = 16;

   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

   localparam logic MODE_REQUEST  = 1'b0;
   localparam logic MODE_RESPONSE = 1'b1;

   localparam logic KIND_TX    = 1'b0;
   localparam logic KIND_CHECK = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
   localparam logic [1:0] STATUS_LEN_ERR = 2'd2;

   // results loaded into the output buffer by one transaction
   typedef struct packed {
      logic       valid;
      logic [1:0] count;
      logic       kind;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] status;
   } push_type;

   // reflected CRC-16, one byte, eight unrolled shift steps
   function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/mrcrc_frame_core.sv
// Input register, CRC and byte-count state, length register and result generation.
`timescale 1ns / 1ps

module mrcrc_frame_core #(
   parameter int MaxFrame = mrcrc_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_mode,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_last_byte,
   input  logic                        csr_wr_en,
   input  logic [mrcrc_pkg::LEN_W-1:0] csr_wr_data,
   input  logic                        buf_free,
   output mrcrc_pkg::push_type         push
);

   localparam int CntW = $clog2(MaxFrame + 2);
   localparam logic [CntW-1:0] CntMax = CntW'(MaxFrame + 1);
   localparam logic [mrcrc_pkg::LEN_W-1:0] LenMax = mrcrc_pkg::LEN_W'(MaxFrame);

   logic                            s1_valid_ff, s1_valid_in;
   logic                            s1_mode_ff;
   logic [7:0]                      s1_data_ff;
   logic                            s1_last_ff;
   logic [mrcrc_pkg::CRC_W-1:0]     crc_ff, crc_in;
   logic [CntW-1:0]                 count_ff, count_in;
   logic [mrcrc_pkg::LEN_W-1:0]     len_ff;

   logic                            accept;
   logic                            advance;
   logic                            no_results;
   logic [mrcrc_pkg::CRC_W-1:0]     crc_next;
   logic [CntW-1:0]                 count_next;
   logic [mrcrc_pkg::LEN_W-1:0]     count_ext;
   logic [1:0]                      status;

   assign no_results = (s1_mode_ff == mrcrc_pkg::MODE_RESPONSE) && !s1_last_ff;
   assign advance    = s1_valid_ff && (no_results || buf_free);
   assign req_stall  = s1_valid_ff && !advance;
   assign accept     = req_valid && !req_stall;

   assign crc_next   = mrcrc_pkg::crc_fold(crc_ff, s1_data_ff);
   assign count_next = (count_ff < CntMax) ? count_ff + CntW'(1) : count_ff;
   assign count_ext  = mrcrc_pkg::LEN_W'(count_next);

   always_comb begin
      if (len_ff > LenMax || count_ext != len_ff) begin
         status = mrcrc_pkg::STATUS_LEN_ERR;
      end else if (crc_next != '0) begin
         status = mrcrc_pkg::STATUS_CRC_ERR;
      end else begin
         status = mrcrc_pkg::STATUS_OK;
      end
   end

   always_comb begin
      push        = '0;
      push.valid  = advance && !no_results;
      push.kind   = mrcrc_pkg::KIND_TX;
      push.status = mrcrc_pkg::STATUS_OK;
      push.byte0  = s1_data_ff;
      push.byte1  = crc_next[7:0];
      push.byte2  = crc_next[15:8];
      push.count  = s1_last_ff ? 2'd3 : 2'd1;
      if (s1_mode_ff == mrcrc_pkg::MODE_RESPONSE) begin
         push.kind   = mrcrc_pkg::KIND_CHECK;
         push.status = status;
         push.byte0  = 8'h00;
         push.count  = 2'd1;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      crc_in   = crc_ff;
      count_in = count_ff;
      if (advance) begin
         if (s1_last_ff) begin
            crc_in   = mrcrc_pkg::CRC_INIT;
            count_in = '0;
         end else begin
            crc_in = crc_next;
            if (s1_mode_ff == mrcrc_pkg::MODE_RESPONSE) begin
               count_in = count_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         crc_ff      <= mrcrc_pkg::CRC_INIT;
         count_ff    <= '0;
         len_ff      <= mrcrc_pkg::LEN_W'(7);
      end else begin
         s1_valid_ff <= s1_valid_in;
         crc_ff      <= crc_in;
         count_ff    <= count_in;
         if (csr_wr_en) begin
            len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff <= req_mode;
         s1_data_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
      end
   end

endmodule

FILE: rtl/mrcrc_result_buffer.sv
// Output register holding up to three results of one transaction, sent one per cycle while rsp_stall is low.
`timescale 1ns / 1ps

module mrcrc_result_buffer (
   input  logic                clock,
   input  logic                reset,
   input  mrcrc_pkg::push_type push,
   output logic                buf_free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_kind,
   output logic [7:0]          rsp_out_byte,
   output logic [1:0]          rsp_status,
   output logic                rsp_end_of_run
);

   logic [1:0] rem_ff, rem_in;
   logic       kind_ff;
   logic [7:0] byte_ff;
   logic [7:0] nxt0_ff;
   logic [7:0] nxt1_ff;
   logic [1:0] status_ff;
   logic       pop;

   assign rsp_valid      = rem_ff != 2'd0;
   assign pop            = rsp_valid && !rsp_stall;
   assign buf_free       = (rem_ff == 2'd0) || ((rem_ff == 2'd1) && !rsp_stall);
   assign rsp_kind       = kind_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_status     = status_ff;
   assign rsp_end_of_run = rem_ff == 2'd1;

   always_comb begin
      rem_in = rem_ff;
      if (push.valid) begin
         rem_in = push.count;
      end else if (pop) begin
         rem_in = rem_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         kind_ff   <= push.kind;
         byte_ff   <= push.byte0;
         nxt0_ff   <= push.byte1;
         nxt1_ff   <= push.byte2;
         status_ff <= push.status;
      end else if (pop) begin
         byte_ff <= nxt0_ff;
         nxt0_ff <= nxt1_ff;
      end
   end

endmodule

FILE: rtl/modbus_rtu_frame_crc_engine_unit.sv
// Top level of the Modbus RTU CRC-16 frame engine.
//
//   channel  direction  handshake                    payload
//   req      in         req_valid / req_stall        req_mode, req_data_byte, req_last_byte
//   rsp      out        rsp_valid / rsp_stall        rsp_kind, rsp_out_byte, rsp_status,
//                                                    rsp_end_of_run
//   csr      in         csr_wr_en                    csr_wr_data (expected length)
//
// A transaction is registered, folded into the CRC and its results loaded into the
// output register; one transaction per cycle is sustained while that register has room.
// A last byte in request mode yields three results, the byte and its two CRC bytes, so req
// stalls while they drain. An accepted byte passes the input register, then the output register.
// Synchronous reset: CRC to 0xFFFF, byte count to zero, expected length to 7.
// rsp_stall holds the output register and, once it is full, stalls req.
`timescale 1ns / 1ps

module modbus_rtu_frame_crc_engine_unit #(
   parameter int MaxFrame = mrcrc_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_mode,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_last_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_kind,
   output logic [7:0]                  rsp_out_byte,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_end_of_run,
   input  logic                        csr_wr_en,
   input  logic [mrcrc_pkg::LEN_W-1:0] csr_wr_data
);

   mrcrc_pkg::push_type push;
   logic                buf_free;

   mrcrc_frame_core #(
      .MaxFrame(MaxFrame)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .buf_free     (buf_free),
      .push         (push)
   );

   mrcrc_result_buffer u_buffer (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .buf_free      (buf_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_status    (rsp_status),
      .rsp_end_of_run(rsp_end_of_run)
   );

endmodule
